// ===== hw/rtl/singly_linked_list_cursor_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// singly linked list cursor engine - assertion macros
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef SINGLY_LINKED_LIST_CURSOR_ENGINE_UNIT_MACROS_SVH
`define SINGLY_LINKED_LIST_CURSOR_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SLLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SLLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define SLLC_ASSERT(lbl, prop, msg)
`define SLLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/sllc_pkg.sv =====
// ----------------------------------------------------------------------------
// sllc_pkg
// shared types and constants of the linked list cursor engine
// ----------------------------------------------------------------------------
`default_nettype none

package sllc_pkg;

    localparam int NODES_DEF      = 256;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int VAL_W          = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD  = 3'd0,
        CMD_CUR_HEAD  = 3'd1,
        CMD_DEL_HEAD  = 3'd2,
        CMD_DEL_AFTER = 3'd3,
        CMD_INS_AFTER = 3'd4,
        CMD_OVERWRITE = 3'd5,
        CMD_ADVANCE   = 3'd6,
        CMD_CLEAR     = 3'd7
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_RD_CUR,
        ST_GET_B,
        ST_WR_NEW,
        ST_WR_LINK,
        ST_DH_NEXT,
        ST_DH_VAL,
        ST_DA_VICT,
        ST_DA_NEXT,
        ST_DA_FREE,
        ST_AD_NEXT,
        ST_AD_VAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             pool_full_error;
        logic             head_present;
        logic [VAL_W-1:0] head_value;
        logic             cursor_present;
        logic [VAL_W-1:0] cursor_value;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/sllc_ram.sv =====
// ----------------------------------------------------------------------------
// sllc_ram
// node pool memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sllc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sllc_seq.sv =====
// ----------------------------------------------------------------------------
// sllc_seq
// command sequencer: list pointers, allocator and node memory traffic
// ----------------------------------------------------------------------------
`default_nettype none

`include "singly_linked_list_cursor_engine_unit_macros.svh"

module sllc_seq
    import sllc_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output t_result                      o_res
);

    localparam int IW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [IW-1:0] NIL = IW'(NODES);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic signed [VALUE_BITS-1:0] r_val, n_val;
    logic signed [VALUE_BITS-1:0] r_head_val, n_head_val;
    logic signed [VALUE_BITS-1:0] r_cur_val, n_cur_val;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_fresh, n_fresh;
    logic [IW-1:0] r_ftop, n_ftop;
    logic [IW-1:0] r_a, n_a;
    logic [IW-1:0] r_b, n_b;
    logic          r_err, n_err;

    logic                  nx_we;
    logic [AW-1:0]         nx_waddr;
    logic [IW-1:0]         nx_wdata;
    logic [AW-1:0]         nx_raddr;
    logic [IW-1:0]         nx_rdata;
    logic                  vl_we;
    logic [AW-1:0]         vl_waddr;
    logic [VALUE_BITS-1:0] vl_wdata;
    logic [AW-1:0]         vl_raddr;
    logic [VALUE_BITS-1:0] vl_rdata;

    logic          nx_live;
    logic [IW-1:0] nx_clean;
    logic          head_live;
    logic          cur_live;
    logic          ftop_live;
    logic          fresh_avail;

    assign nx_live     = nx_rdata < NIL;
    assign nx_clean    = nx_live ? nx_rdata : NIL;
    assign head_live   = r_head < NIL;
    assign cur_live    = r_cur < NIL;
    assign ftop_live   = r_ftop < NIL;
    assign fresh_avail = r_fresh < NIL;

    sllc_ram #(
        .WIDTH(IW),
        .DEPTH(NODES)
    ) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (nx_we),
        .i_waddr(nx_waddr),
        .i_wdata(nx_wdata),
        .i_raddr(nx_raddr),
        .o_rdata(nx_rdata)
    );

    sllc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(NODES)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (vl_we),
        .i_waddr(vl_waddr),
        .i_wdata(vl_wdata),
        .i_raddr(vl_raddr),
        .o_rdata(vl_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_cmd) inside
                    CMD_INS_HEAD, CMD_INS_AFTER: begin
                        if (r_cmd == CMD_INS_AFTER && !cur_live) begin
                            n_state = ST_DONE;
                        end else if (fresh_avail) begin
                            n_state = (r_cmd == CMD_INS_HEAD) ? ST_WR_NEW : ST_RD_CUR;
                        end else if (ftop_live) begin
                            n_state = ST_POP;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    CMD_DEL_HEAD:  n_state = head_live ? ST_DH_NEXT : ST_DONE;
                    CMD_DEL_AFTER: n_state = cur_live ? ST_DA_VICT : ST_DONE;
                    CMD_ADVANCE:   n_state = cur_live ? ST_AD_NEXT : ST_DONE;
                    CMD_CUR_HEAD, CMD_OVERWRITE, CMD_CLEAR: n_state = ST_DONE;
                endcase
            end
            ST_POP:     n_state = (r_cmd == CMD_INS_HEAD) ? ST_WR_NEW : ST_GET_B;
            ST_RD_CUR:  n_state = ST_GET_B;
            ST_GET_B:   n_state = ST_WR_NEW;
            ST_WR_NEW:  n_state = (r_cmd == CMD_INS_HEAD) ? ST_DONE : ST_WR_LINK;
            ST_WR_LINK: n_state = ST_DONE;
            ST_DH_NEXT: n_state = nx_live ? ST_DH_VAL : ST_DONE;
            ST_DH_VAL:  n_state = ST_DONE;
            ST_DA_VICT: n_state = nx_live ? ST_DA_NEXT : ST_DONE;
            ST_DA_NEXT: n_state = ST_DA_FREE;
            ST_DA_FREE: n_state = ST_DONE;
            ST_AD_NEXT: n_state = nx_live ? ST_AD_VAL : ST_DONE;
            ST_AD_VAL:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_head_val = r_head_val;
        n_cur_val  = r_cur_val;
        n_head     = r_head;
        n_cur      = r_cur;
        n_fresh    = r_fresh;
        n_ftop     = r_ftop;
        n_a        = r_a;
        n_b        = r_b;
        n_err      = r_err;
        nx_we      = 1'b0;
        nx_waddr   = r_a[AW-1:0];
        nx_wdata   = r_ftop;
        nx_raddr   = r_cur[AW-1:0];
        vl_we      = 1'b0;
        vl_waddr   = r_a[AW-1:0];
        vl_wdata   = r_val;
        vl_raddr   = nx_rdata[AW-1:0];
        o_ready    = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd = t_cmd'(i_cmd);
                    n_val = VALUE_BITS'(i_value);
                    n_err = 1'b0;
                end
            end
            ST_EXEC: begin
                unique case (r_cmd) inside
                    CMD_INS_HEAD, CMD_INS_AFTER: begin
                        if (!(r_cmd == CMD_INS_AFTER && !cur_live)) begin
                            if (fresh_avail) begin
                                n_a     = r_fresh;
                                n_fresh = r_fresh + IW'(1);
                            end else if (ftop_live) begin
                                n_a      = r_ftop;
                                nx_raddr = r_ftop[AW-1:0];
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    CMD_CUR_HEAD: begin
                        n_cur     = r_head;
                        n_cur_val = r_head_val;
                    end
                    CMD_DEL_HEAD: begin
                        nx_raddr = r_head[AW-1:0];
                        n_a      = r_head;
                    end
                    CMD_DEL_AFTER, CMD_ADVANCE: begin
                        nx_raddr = r_cur[AW-1:0];
                    end
                    CMD_OVERWRITE: begin
                        if (cur_live) begin
                            vl_we     = 1'b1;
                            vl_waddr  = r_cur[AW-1:0];
                            vl_wdata  = r_val;
                            n_cur_val = r_val;
                            if (r_head == r_cur) begin
                                n_head_val = r_val;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        n_head     = NIL;
                        n_cur      = NIL;
                        n_fresh    = '0;
                        n_ftop     = NIL;
                        n_head_val = '0;
                        n_cur_val  = '0;
                    end
                endcase
            end
            ST_POP: begin
                n_ftop   = nx_clean;
                nx_raddr = r_cur[AW-1:0];
            end
            ST_RD_CUR: begin
                nx_raddr = r_cur[AW-1:0];
            end
            ST_GET_B: begin
                n_b = nx_clean;
            end
            ST_WR_NEW: begin
                vl_we    = 1'b1;
                vl_waddr = r_a[AW-1:0];
                vl_wdata = r_val;
                nx_we    = 1'b1;
                nx_waddr = r_a[AW-1:0];
                nx_wdata = (r_cmd == CMD_INS_HEAD) ? r_head : r_b;
                if (r_cmd == CMD_INS_HEAD) begin
                    n_head     = r_a;
                    n_head_val = r_val;
                end
            end
            ST_WR_LINK: begin
                nx_we    = 1'b1;
                nx_waddr = r_cur[AW-1:0];
                nx_wdata = r_a;
            end
            ST_DH_NEXT: begin
                n_head   = nx_clean;
                nx_we    = 1'b1;
                nx_waddr = r_a[AW-1:0];
                nx_wdata = r_ftop;
                n_ftop   = r_a;
                vl_raddr = nx_rdata[AW-1:0];
                if (r_cur == r_a) begin
                    n_cur     = NIL;
                    n_cur_val = '0;
                end
                if (!nx_live) begin
                    n_head_val = '0;
                end
            end
            ST_DH_VAL: begin
                n_head_val = vl_rdata;
            end
            ST_DA_VICT: begin
                n_a      = nx_rdata;
                nx_raddr = nx_rdata[AW-1:0];
            end
            ST_DA_NEXT: begin
                nx_we    = 1'b1;
                nx_waddr = r_cur[AW-1:0];
                nx_wdata = nx_clean;
            end
            ST_DA_FREE: begin
                nx_we    = 1'b1;
                nx_waddr = r_a[AW-1:0];
                nx_wdata = r_ftop;
                n_ftop   = r_a;
            end
            ST_AD_NEXT: begin
                n_cur    = nx_clean;
                vl_raddr = nx_rdata[AW-1:0];
                if (!nx_live) begin
                    n_cur_val = '0;
                end
            end
            ST_AD_VAL: begin
                n_cur_val = vl_rdata;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res.pool_full_error = r_err;
        o_res.head_present    = head_live;
        o_res.head_value      = VAL_W'(r_head_val);
        o_res.cursor_present  = cur_live;
        o_res.cursor_value    = VAL_W'(r_cur_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= NIL;
            r_cur      <= NIL;
            r_fresh    <= '0;
            r_ftop     <= NIL;
            r_head_val <= '0;
            r_cur_val  <= '0;
            r_err      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_cur      <= n_cur;
            r_fresh    <= n_fresh;
            r_ftop     <= n_ftop;
            r_head_val <= n_head_val;
            r_cur_val  <= n_cur_val;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_val <= n_val;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    `SLLC_ASSERT(a_cur_needs_head, (r_cur != NIL) |-> (r_head != NIL), "cursor without head")
    `SLLC_ASSERT(a_head_val_null, (r_head == NIL) |-> (r_head_val == '0), "stale head value")
    `SLLC_ASSERT(a_cur_val_null, (r_cur == NIL) |-> (r_cur_val == '0), "stale cursor value")
    `SLLC_ASSERT(a_fresh_range, r_fresh <= NIL, "bump counter past pool")

endmodule

`default_nettype wire

// ===== hw/rtl/singly_linked_list_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// singly_linked_list_cursor_engine_unit
// linked list with cursor over a node pool, one result per command
//
// input channel i_valid / o_ready carries i_cmd and i_value; every accepted
// command gives exactly one result on o_valid / i_ready with the error flag,
// the head and cursor flags and their values.
// the time from transfer to result register depends on the command: the
// node link memory has one read port with a registered read, so each
// pointer hop waits for its read; insert after cursor is the longest.
// o_ready is high only while no command is in progress, so one command is
// in flight at a time and the next is taken only once the last is done.
// the result sits in an output register; if the receiver stalls the engine
// holds its finished result until the register frees, and then takes the
// next command.
// reset (synchronous, active low) empties the list, the cursor and the free
// stack at once; node memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "singly_linked_list_cursor_engine_unit_macros.svh"

module singly_linked_list_cursor_engine_unit
    import sllc_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_pool_full_error,
    output logic                         o_head_present,
    output logic signed [VAL_W-1:0]      o_head_value,
    output logic                         o_cursor_present,
    output logic signed [VAL_W-1:0]      o_cursor_value
);

    t_result w_res;
    logic    w_res_valid;
    logic    w_res_ready;
    logic    r_valid;
    t_result r_res;

    assign w_res_ready = !r_valid || i_ready;

    sllc_seq #(
        .NODES     (NODES),
        .VALUE_BITS(VALUE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .o_res_valid(w_res_valid),
        .i_res_ready(w_res_ready),
        .o_res      (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_res <= w_res;
        end
    end

    assign o_valid           = r_valid;
    assign o_pool_full_error = r_res.pool_full_error;
    assign o_head_present    = r_res.head_present;
    assign o_head_value      = r_res.head_value;
    assign o_cursor_present  = r_res.cursor_present;
    assign o_cursor_value    = r_res.cursor_value;

    `SLLC_ASSERT(a_res_held, w_res_valid && !w_res_ready |=> w_res_valid, "result dropped")
    `SLLC_ASSERT(a_idle_no_res, o_ready |-> !w_res_valid, "result while accepting")
    `SLLC_ASSERT(a_out_cur_head, o_valid && o_cursor_present |-> o_head_present, "cursor no head")

endmodule

`default_nettype wire

// ===== tb/tb_singly_linked_list_cursor_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_singly_linked_list_cursor_engine_unit
// self-checking bench for the linked list cursor engine
//
// a directed table covers the empty list, the value extremes and the cursor
// corner cases, then random segments mix list edits, drain the list, and
// fill the pool until inserts are refused. fixed rows are checked with the
// table, the rest with a local model of node pool, free stack, head, cursor.
// the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_singly_linked_list_cursor_engine_unit
    import sllc_pkg::*;
;

    localparam int NODES      = NODES_DEF;
    localparam int IDX_W      = $clog2(NODES_DEF) + 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_ITEMS    = 1050;

    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx NIL = t_idx'(NODES);

    typedef struct {
        t_cmd        cmd;
        logic [31:0] val;
        bit          fixed;
        t_result     want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [CMD_W-1:0]  i_cmd = CMD_INS_HEAD;
    logic [VAL_W-1:0]  i_value = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_pool_full_error;
    logic              o_head_present;
    logic [VAL_W-1:0]  o_head_value;
    logic              o_cursor_present;
    logic [VAL_W-1:0]  o_cursor_value;

    // list model
    logic [31:0] pool_val [NODES];
    t_idx        pool_next [NODES];
    t_idx        head_ix = NIL;
    t_idx        cur_ix = NIL;
    t_idx        fresh_cnt = '0;
    t_idx        free_ix = NIL;

    t_result     result_q [$];
    int          cmd_count [8];
    int          n_sent = 0;
    int          n_checked = 0;
    int          fail_count = 0;
    int          full_hits = 0;
    int          reuse_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int          rx_hold = 0;

    singly_linked_list_cursor_engine_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_value           (i_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pool_full_error (o_pool_full_error),
        .o_head_present    (o_head_present),
        .o_head_value      (o_head_value),
        .o_cursor_present  (o_cursor_present),
        .o_cursor_value    (o_cursor_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit is_live(t_idx i);
        return i < NODES;
    endfunction

    function automatic t_idx take_node();
        t_idx n;
        n = NIL;
        if (fresh_cnt < NODES) begin
            n = fresh_cnt;
            fresh_cnt++;
        end else if (is_live(free_ix)) begin
            n = free_ix;
            free_ix = pool_next[n];
            reuse_count++;
        end
        return n;
    endfunction

    function automatic void give_node(t_idx n);
        if (is_live(n)) begin
            pool_next[n] = free_ix;
            free_ix = n;
        end
    endfunction

    function automatic t_result step_list(t_cmd c, logic [31:0] v);
        t_result r;
        t_idx    n;
        t_idx    victim;
        r = '0;
        case (c)
            CMD_INS_HEAD: begin
                n = take_node();
                if (!is_live(n)) begin
                    r.pool_full_error = 1'b1;
                end else begin
                    pool_val[n]  = v;
                    pool_next[n] = is_live(head_ix) ? head_ix : NIL;
                    head_ix      = n;
                end
            end
            CMD_CUR_HEAD: begin
                cur_ix = is_live(head_ix) ? head_ix : NIL;
            end
            CMD_DEL_HEAD: begin
                if (is_live(head_ix)) begin
                    victim  = head_ix;
                    head_ix = is_live(pool_next[victim]) ? pool_next[victim] : NIL;
                    if (cur_ix == victim) begin
                        cur_ix = NIL;
                    end
                    give_node(victim);
                end
            end
            CMD_DEL_AFTER: begin
                if (is_live(cur_ix) && is_live(pool_next[cur_ix])) begin
                    victim = pool_next[cur_ix];
                    pool_next[cur_ix] = is_live(pool_next[victim]) ? pool_next[victim] : NIL;
                    give_node(victim);
                end
            end
            CMD_INS_AFTER: begin
                if (is_live(cur_ix)) begin
                    n = take_node();
                    if (!is_live(n)) begin
                        r.pool_full_error = 1'b1;
                    end else begin
                        pool_val[n]  = v;
                        pool_next[n] = is_live(pool_next[cur_ix]) ? pool_next[cur_ix] : NIL;
                        pool_next[cur_ix] = n;
                    end
                end
            end
            CMD_OVERWRITE: begin
                if (is_live(cur_ix)) begin
                    pool_val[cur_ix] = v;
                end
            end
            CMD_ADVANCE: begin
                if (is_live(cur_ix)) begin
                    cur_ix = is_live(pool_next[cur_ix]) ? pool_next[cur_ix] : NIL;
                end
            end
            default: begin
                head_ix   = NIL;
                cur_ix    = NIL;
                fresh_cnt = '0;
                free_ix   = NIL;
            end
        endcase
        r.head_present   = is_live(head_ix);
        r.head_value     = is_live(head_ix) ? pool_val[head_ix] : '0;
        r.cursor_present = is_live(cur_ix);
        r.cursor_value   = is_live(cur_ix) ? pool_val[cur_ix] : '0;
        if (r.pool_full_error) begin
            full_hits++;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row mk_row(t_cmd c, logic [31:0] v, int fixed, int e,
                                    int hp, logic [31:0] hv, int cp, logic [31:0] cv);
        t_row row;
        row.cmd   = c;
        row.val   = v;
        row.fixed = (fixed != 0);
        row.want  = '{pool_full_error: (e != 0), head_present: (hp != 0), head_value: hv,
                      cursor_present: (cp != 0), cursor_value: cv};
        return row;
    endfunction

    // one command transfer, then queue the expected result
    task automatic push_cmd(input t_cmd c, input logic [31:0] v, input bit fixed,
                            input t_result want);
        t_result predicted;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_cmd   <= c;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        predicted = step_list(c, v);
        result_q.push_back(fixed ? want : predicted);
        cmd_count[c]++;
        n_sent++;
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(32, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= (rx_left % 3) != 0;
            default: begin
                if (rx_hold > 0) begin
                    i_ready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) begin
                        rx_hold <= $urandom_range(5, 20);
                    end
                end
            end
        endcase
    end

    // result check
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: err=%0b hp=%0b hv=%h cp=%0b cv=%h",
                             o_pool_full_error, o_head_present, o_head_value,
                             o_cursor_present, o_cursor_value);
                end
            end else begin
                want = result_q.pop_front();
                if (o_pool_full_error !== want.pool_full_error ||
                    o_head_present !== want.head_present ||
                    o_head_value !== want.head_value ||
                    o_cursor_present !== want.cursor_present ||
                    o_cursor_value !== want.cursor_value) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result %0d: want err=%0b hp=%0b hv=%h cp=%0b cv=%h",
                                 n_checked, want.pool_full_error, want.head_present,
                                 want.head_value, want.cursor_present, want.cursor_value);
                        $display("result %0d: got  err=%0b hp=%0b hv=%h cp=%0b cv=%h",
                                 n_checked, o_pool_full_error, o_head_present,
                                 o_head_value, o_cursor_present, o_cursor_value);
                    end
                end
                n_checked++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        t_row    rows [$];
        t_cmd    c;
        int      seg;
        int      len;
        int      r;
        int      target;
        rows.push_back(mk_row(CMD_CUR_HEAD,  32'h0,         1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DEL_HEAD,  32'h0,         1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DEL_AFTER, 32'h0,         1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_INS_AFTER, 32'h1234_5678, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_OVERWRITE, 32'h0000_5555, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_INS_HEAD,  32'h7fff_ffff, 1, 0, 1, 32'h7fff_ffff, 0, 0));
        rows.push_back(mk_row(CMD_INS_HEAD,  32'h8000_0000, 1, 0, 1, 32'h8000_0000, 0, 0));
        rows.push_back(mk_row(CMD_CUR_HEAD,  32'h0,         1, 0, 1, 32'h8000_0000,
                              1, 32'h8000_0000));
        rows.push_back(mk_row(CMD_OVERWRITE, 32'hffff_ffff, 1, 0, 1, 32'hffff_ffff,
                              1, 32'hffff_ffff));
        rows.push_back(mk_row(CMD_INS_AFTER, 32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_CUR_HEAD,  32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DEL_AFTER, 32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ADVANCE,   32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DEL_AFTER, 32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_CUR_HEAD,  32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_DEL_HEAD,  32'h0,         0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_INS_HEAD,  32'ha5a5_a5a5, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_CLEAR,     32'h0,         1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(CMD_INS_HEAD,  32'h0000_0001, 1, 0, 1, 32'h1, 0, 0));
        rows.push_back(mk_row(CMD_CLEAR,     32'hffff_ffff, 1, 0, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            push_cmd(rows[k].cmd, rows[k].val, rows[k].fixed, rows[k].want);
        end

        seg = 0;
        while (n_sent < N_ITEMS) begin
            if (seg == 1 || seg == 9) begin
                // fill the pool from empty until inserts are refused
                push_cmd(CMD_CLEAR, $urandom, 1'b0, '0);
                target = full_hits + 3;
                while (full_hits < target) begin
                    r = $urandom_range(0, 99);
                    if (r < 75) c = CMD_INS_HEAD;
                    else if (r < 90) c = CMD_INS_AFTER;
                    else if (r < 95) c = CMD_CUR_HEAD;
                    else c = CMD_ADVANCE;
                    push_cmd(c, rand_value(), 1'b0, '0);
                end
            end else begin
                len = $urandom_range(10, 40);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (seg % 5 == 3) begin
                        if (r < 10) c = CMD_CUR_HEAD;
                        else if (r < 55) c = CMD_DEL_HEAD;
                        else if (r < 85) c = CMD_DEL_AFTER;
                        else if (r < 95) c = CMD_ADVANCE;
                        else c = CMD_INS_AFTER;
                    end else begin
                        if (r < 22) c = CMD_INS_HEAD;
                        else if (r < 30) c = CMD_CUR_HEAD;
                        else if (r < 44) c = CMD_DEL_HEAD;
                        else if (r < 58) c = CMD_DEL_AFTER;
                        else if (r < 74) c = CMD_INS_AFTER;
                        else if (r < 82) c = CMD_OVERWRITE;
                        else if (r < 97) c = CMD_ADVANCE;
                        else c = CMD_CLEAR;
                    end
                    push_cmd(c, rand_value(), 1'b0, '0);
                end
            end
            seg++;
        end
        i_valid <= 1'b0;

        wait (result_q.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("%0d commands, %0d results checked; ins_head %0d cur_head %0d del_head %0d",
                 n_sent, n_checked, cmd_count[CMD_INS_HEAD], cmd_count[CMD_CUR_HEAD],
                 cmd_count[CMD_DEL_HEAD]);
        $display("del_after %0d ins_after %0d overwrite %0d advance %0d clear %0d; %0d %s %0d",
                 cmd_count[CMD_DEL_AFTER], cmd_count[CMD_INS_AFTER], cmd_count[CMD_OVERWRITE],
                 cmd_count[CMD_ADVANCE], cmd_count[CMD_CLEAR], full_hits,
                 "refused inserts, free node reuses", reuse_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
